// File: design/ghbp_pkg.sv
// Shared constants and types for the global history branch predictor.
package ghbp_pkg;

  localparam int HISTORY_BITS = 8;
  localparam int THREADS      = 4;

  localparam int TABLE_DEPTH = 1 << HISTORY_BITS;
  localparam int THREAD_W    = (THREADS > 1) ? $clog2(THREADS) : 1;

  localparam int CTR_W    = 8;
  localparam int REQ_W    = 3;
  localparam int TID_W    = 2;
  localparam int ADDR_W   = 64;
  localparam int SNAP_W   = 8;
  localparam int CBITS_W  = 4;
  localparam int SHIFT_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [CBITS_W-1:0] CBITS_RST = CBITS_W'(2);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(2);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 3'd0,
    REQ_UNCOND = 3'd1,
    REQ_BTB_MISS = 3'd2,
    REQ_UPDATE = 3'd3,
    REQ_SQUASH = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTER_BITS = 2'd0,
    REG_INST_SHIFT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: design/ghbp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ghbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/global_history_branch_predictor.sv
// Global history branch direction predictor: top level.
//
// The pattern table is read in the cycle a request word is accepted, and the
// counter update, history update and result are produced in the execute state
// from the registered read data, so a new word is not taken until the last one
// has finished execute, because of the registered read of the pattern counter
// RAM and the write-back that follows it. After
// reset the table is cleared one entry per cycle over all 2**HISTORY_BITS (256)
// entries, during which in_ready stays low; configuration writes are always taken. A
// finished result sits in the output register while the next word is accepted;
// a request only stalls in execute if that register is full and out_ready is low.
module global_history_branch_predictor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ghbp_pkg::REQ_W-1:0]      in_req_type,
  input  logic [ghbp_pkg::TID_W-1:0]      in_thread_id,
  input  logic [ghbp_pkg::ADDR_W-1:0]     in_branch_addr,
  input  logic                            in_outcome_taken,
  input  logic                            in_was_mispredicted,
  input  logic [ghbp_pkg::SNAP_W-1:0]     in_saved_history,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_predict_taken,
  output logic [ghbp_pkg::SNAP_W-1:0]     out_history_snapshot,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ghbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ghbp_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import ghbp_pkg::*;

  localparam int HB = HISTORY_BITS;

  state_t state_r, state_nxt;

  logic [CBITS_W-1:0] cbits_r;
  logic [SHIFT_W-1:0] shift_r;

  logic [HB-1:0] hist_r [THREADS];
  logic [HB-1:0] clr_idx_r;

  logic [REQ_W-1:0]  req_r;
  logic              tok_r;
  logic [THREAD_W-1:0] tid_r;
  logic              taken_r;
  logic              mis_r;
  logic [HB-1:0]     saved_r;
  logic [HB-1:0]     idx_r;
  logic [HB-1:0]     snap_r;

  logic              out_valid_r;
  logic              out_pred_r;
  logic [SNAP_W-1:0] out_snap_r;

  logic              accept;
  logic              exec_done;
  logic              ram_we;
  logic [HB-1:0]     ram_waddr;
  logic [CTR_W-1:0]  ram_wdata;
  logic [CTR_W-1:0]  ram_rdata;

  logic [THREAD_W-1:0] tid_in;
  logic              tok_in;
  logic [HB-1:0]     snap_in;
  logic [HB-1:0]     saved_in;
  logic [HB-1:0]     pc_in;
  logic [HB-1:0]     idx_in;

  logic [CBITS_W-1:0] eff_bits;
  logic [CTR_W:0]     half_v;
  logic [CTR_W:0]     max_v;
  logic               ctr_pred;
  logic [CTR_W-1:0]   ctr_nxt;
  logic               pred;
  logic [HB-1:0]      hist_nxt;
  logic               hist_we;
  logic               ctr_we;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbits_r <= CBITS_RST;
      shift_r <= SHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNTER_BITS: cbits_r <= cfg_data;
        REG_INST_SHIFT:   shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_idx_r == {HB{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    exec_done = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_EXEC:  exec_done = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + HB'(1);
      end
    end
  end

  // request decode at accept
  assign tid_in   = THREAD_W'(in_thread_id);
  assign tok_in   = int'(in_thread_id) < THREADS;
  assign snap_in  = hist_r[tid_in];
  assign saved_in = HB'(in_saved_history);
  assign pc_in    = HB'(in_branch_addr >> shift_r);
  assign idx_in   = (in_req_type == REQ_UPDATE) ? ~(pc_in ^ saved_in) : ~(pc_in ^ snap_in);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      tok_r   <= tok_in;
      tid_r   <= tid_in;
      taken_r <= in_outcome_taken;
      mis_r   <= in_was_mispredicted;
      saved_r <= saved_in;
      idx_r   <= idx_in;
      snap_r  <= tok_in ? snap_in : '0;
    end
  end

  // counter math
  always_comb begin
    if (cbits_r == '0) begin
      eff_bits = CBITS_W'(1);
    end else if (cbits_r > CBITS_W'(CTR_W)) begin
      eff_bits = CBITS_W'(CTR_W);
    end else begin
      eff_bits = cbits_r;
    end
  end

  assign half_v   = (CTR_W+1)'(1) << (eff_bits - CBITS_W'(1));
  assign max_v    = ((CTR_W+1)'(1) << eff_bits) - (CTR_W+1)'(1);
  assign ctr_pred = {1'b0, ram_rdata} >= half_v;

  always_comb begin
    ctr_nxt = ram_rdata;
    if (taken_r) begin
      if ({1'b0, ram_rdata} < max_v) ctr_nxt = ram_rdata + CTR_W'(1);
    end else begin
      if (ram_rdata != '0) ctr_nxt = ram_rdata - CTR_W'(1);
    end
  end

  always_comb begin
    pred     = 1'b0;
    hist_nxt = snap_r;
    hist_we  = 1'b0;
    ctr_we   = 1'b0;
    case (req_r)
      REQ_LOOKUP: begin
        pred     = ctr_pred;
        hist_nxt = HB'({snap_r, ctr_pred});
        hist_we  = 1'b1;
      end
      REQ_UNCOND: begin
        pred     = 1'b1;
        hist_nxt = HB'({snap_r, 1'b1});
        hist_we  = 1'b1;
      end
      REQ_BTB_MISS: begin
        hist_nxt = snap_r & ~HB'(1);
        hist_we  = 1'b1;
      end
      REQ_UPDATE: begin
        ctr_we   = 1'b1;
        hist_nxt = HB'({saved_r, taken_r});
        hist_we  = mis_r;
      end
      REQ_SQUASH: begin
        hist_nxt = saved_r;
        hist_we  = 1'b1;
      end
      default: ;
    endcase
    if (!tok_r) begin
      pred    = 1'b0;
      hist_we = 1'b0;
      ctr_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREADS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (exec_done && hist_we) begin
      hist_r[tid_r] <= hist_nxt;
    end
  end

  // pattern table
  assign ram_we    = (state_r == ST_CLEAR) || (exec_done && ctr_we);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_idx_r : idx_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : ctr_nxt;

  ghbp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (idx_in),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_pred_r <= pred;
      out_snap_r <= SNAP_W'(snap_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_predict_taken    = out_pred_r;
  assign out_history_snapshot = out_snap_r;

endmodule

// File: design/ghbp_checker.sv
// Port-level assertions for the global history branch predictor, bound to the top.
module ghbp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_predict_taken,
  input logic [ghbp_pkg::SNAP_W-1:0]     out_history_snapshot
);
  import ghbp_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_predict_taken)
      && $stable(out_history_snapshot))
    else $error("result word changed while stalled");

  // table clear runs after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during table clear");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // results come only out of the execute cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a request in execute");

endmodule

bind global_history_branch_predictor ghbp_checker u_ghbp_checker (.*);
